// ----- sv/ptb_pkg.sv -----
// shared constants, command codes and timer record type for the timer bank
package ptb_pkg;

   localparam int NUM_TIMERS   = 8;
   localparam int TICK_STEP_MS = 1;
   localparam int TIDX_W       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int MASK_W       = 8;

   localparam logic [7:0]  LOOP_FOREVER = 8'd255;
   localparam logic [31:0] TICK_STEP    = 32'(TICK_STEP_MS);

   localparam logic [2:0] CMD_TICK   = 3'd0;
   localparam logic [2:0] CMD_START  = 3'd1;
   localparam logic [2:0] CMD_STOP   = 3'd2;
   localparam logic [2:0] CMD_PAUSE  = 3'd3;
   localparam logic [2:0] CMD_RESUME = 3'd4;

   typedef struct packed {
      logic        active;
      logic        paused;
      logic [31:0] remaining;
      logic [31:0] reload;
      logic [7:0]  loops;
   } ptb_rec_type;

endpackage

// ----- sv/ptb_step.sv -----
// shared per-timer update unit: one compare and subtract, then reload or stop
module ptb_step (
   input  ptb_pkg::ptb_rec_type cur,
   output ptb_pkg::ptb_rec_type nxt,
   output logic                 expired
);
   import ptb_pkg::*;

   always_comb begin
      nxt     = cur;
      expired = 1'b0;
      if (cur.active && !cur.paused) begin
         if (cur.remaining > TICK_STEP) begin
            nxt.remaining = cur.remaining - TICK_STEP;
         end else begin
            expired = 1'b1;
            if (cur.loops == LOOP_FOREVER) begin
               nxt.remaining = cur.reload;
            end else if (cur.loops > 8'd1) begin
               nxt.loops     = cur.loops - 8'd1;
               nxt.remaining = cur.reload;
            end else begin
               nxt.loops     = 8'd0;
               nxt.remaining = 32'd0;
               nxt.active    = 1'b0;
            end
         end
      end
   end

endmodule

// ----- sv/periodic_timer_bank_top.sv -----
// periodic timer bank: command decode, timer walk sequencer and result register
//
// usage:
//   the req channel carries one command item: tick, start, stop, pause or
//   resume, with timer index, reload period and loop count. only a tick gives
//   a result item on the rsp channel: the mask of timers that expired on that
//   tick and the free-running millisecond count after it.
//   start, stop, pause and resume update the addressed timer and the block is
//   ready again on the next cycle. a tick walks the bank: one shared compare
//   and subtract unit visits one timer per cycle, then the result is loaded
//   into the output register. req_stall is high while a tick walks the bank.
//   the output register lets the block take the next command while a result
//   still waits; if the receiver stalls and a second tick finishes its walk,
//   the block holds req_stall until the older result has been taken.
//   reset (synchronous, active high) stops and clears every timer and zeroes
//   the time count; no result is pending after reset.
module periodic_timer_bank_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic [2:0]  req_timer_index,
   input  logic [31:0] req_period_ms,
   input  logic [7:0]  req_loop_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_expired_mask,
   output logic [31:0] rsp_time_ms
);
   import ptb_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DELIVER
   } state_type;

   localparam logic [TIDX_W-1:0] LAST_IDX = TIDX_W'(NUM_TIMERS - 1);

   state_type          state_ff, state_in;
   logic [TIDX_W-1:0]  walk_idx_ff, walk_idx_in;
   logic [MASK_W-1:0]  mask_ff, mask_in;
   logic [31:0]        tick_count_ff, tick_count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [MASK_W-1:0]  rsp_mask_ff, rsp_mask_in;
   logic [31:0]        rsp_time_ff, rsp_time_in;

   ptb_rec_type        timers_ff [NUM_TIMERS];

   logic               req_take;
   logic [TIDX_W-1:0]  cmd_idx;
   logic               cmd_idx_ok;
   logic [TIDX_W-1:0]  rd_idx;
   ptb_rec_type        rd_rec;
   ptb_rec_type        step_rec;
   logic               step_expired;
   logic               wr_en;
   logic [TIDX_W-1:0]  wr_idx;
   ptb_rec_type        wr_rec;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign cmd_idx    = TIDX_W'(req_timer_index);
   assign cmd_idx_ok = (32'(req_timer_index) < 32'(NUM_TIMERS));

   // single read port, shared by command decode and the walk
   assign rd_idx = (state_ff == ST_WALK) ? walk_idx_ff : cmd_idx;
   assign rd_rec = timers_ff[rd_idx];

   ptb_step u_step (
      .cur     (rd_rec),
      .nxt     (step_rec),
      .expired (step_expired)
   );

   always_comb begin
      state_in      = state_ff;
      walk_idx_in   = walk_idx_ff;
      mask_in       = mask_ff;
      tick_count_in = tick_count_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_mask_in   = rsp_mask_ff;
      rsp_time_in   = rsp_time_ff;
      wr_en         = 1'b0;
      wr_idx        = rd_idx;
      wr_rec        = rd_rec;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_command == CMD_TICK) begin
                  tick_count_in = tick_count_ff + TICK_STEP;
                  walk_idx_in   = '0;
                  mask_in       = '0;
                  state_in      = ST_WALK;
               end else if (cmd_idx_ok) begin
                  case (req_command)
                     CMD_START: begin
                        wr_en            = 1'b1;
                        wr_rec.active    = 1'b1;
                        wr_rec.paused    = 1'b0;
                        wr_rec.remaining = req_period_ms;
                        wr_rec.reload    = req_period_ms;
                        wr_rec.loops     = req_loop_count;
                     end
                     CMD_STOP: begin
                        wr_en            = 1'b1;
                        wr_rec.active    = 1'b0;
                        wr_rec.paused    = 1'b0;
                        wr_rec.remaining = 32'd0;
                     end
                     CMD_PAUSE: begin
                        wr_en = rd_rec.active;
                        wr_rec.paused = 1'b1;
                     end
                     CMD_RESUME: begin
                        wr_en = rd_rec.active;
                        wr_rec.paused = 1'b0;
                     end
                     default: begin
                        wr_en = 1'b0;
                     end
                  endcase
               end
            end
         end
         ST_WALK: begin
            wr_en   = 1'b1;
            wr_rec  = step_rec;
            // timers beyond the mask width shift out of it
            mask_in = mask_ff | (MASK_W'(step_expired) << walk_idx_ff);
            if (walk_idx_ff == LAST_IDX) begin
               state_in = ST_DELIVER;
            end else begin
               walk_idx_in = walk_idx_ff + 1'b1;
            end
         end
         ST_DELIVER: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_mask_in  = mask_ff;
               rsp_time_in  = tick_count_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         walk_idx_ff   <= '0;
         mask_ff       <= '0;
         tick_count_ff <= 32'd0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < NUM_TIMERS; i++) begin
            timers_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         walk_idx_ff   <= walk_idx_in;
         mask_ff       <= mask_in;
         tick_count_ff <= tick_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (wr_en) begin
            timers_ff[wr_idx] <= wr_rec;
         end
      end
      rsp_mask_ff <= rsp_mask_in;
      rsp_time_ff <= rsp_time_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_expired_mask = rsp_mask_ff;
   assign rsp_time_ms      = rsp_time_ff;

   // a tick starts a walk from timer zero
   a_tick_walks: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_command == CMD_TICK) |=> (state_ff == ST_WALK && walk_idx_ff == '0))
      else $error("tick did not start walk at timer zero");

   // commands other than tick never produce a result
   a_cmd_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_command != CMD_TICK && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("non-tick command produced a result");

   // a new result only appears after the walk has finished
   a_rsp_after_walk: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DELIVER))
      else $error("result raised outside delivery");

   // time count advances only when a tick is taken
   a_time_on_tick: assert property (@(posedge clock) disable iff (reset)
      !(req_take && req_command == CMD_TICK) |=> $stable(tick_count_ff))
      else $error("time count changed without a tick");

endmodule

// ----- tb/sv/periodic_timer_bank_top_tb.sv -----
// self-checking testbench for the periodic timer bank: directed and random command traffic
module periodic_timer_bank_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ptb_pkg::*;

   typedef struct packed {
      logic [7:0]  mask;
      logic [31:0] now_ms;
   } tick_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_command = CMD_TICK;
   logic [2:0]  req_timer_index = '0;
   logic [31:0] req_period_ms = '0;
   logic [7:0]  req_loop_count = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_expired_mask;
   logic [31:0] rsp_time_ms;

   // shadow copy of the timer bank
   bit          tmr_active    [NUM_TIMERS];
   bit          tmr_paused    [NUM_TIMERS];
   logic [31:0] tmr_remaining [NUM_TIMERS];
   logic [31:0] tmr_reload    [NUM_TIMERS];
   logic [7:0]  tmr_loops     [NUM_TIMERS];
   logic [31:0] bank_ms;

   tick_result_type pending_ticks[$];

   int  errors = 0;
   int  items_accepted = 0;
   int  ticks_checked = 0;
   int  expirations_seen = 0;
   bit  no_idle = 1'b0;
   int  rsp_burst_left = 0;

   periodic_timer_bank_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_timer_index  (req_timer_index),
      .req_period_ms    (req_period_ms),
      .req_loop_count   (req_loop_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_expired_mask (rsp_expired_mask),
      .rsp_time_ms      (rsp_time_ms)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic void clear_bank();
      for (int t = 0; t < NUM_TIMERS; t++) begin
         tmr_active[t]    = 1'b0;
         tmr_paused[t]    = 1'b0;
         tmr_remaining[t] = '0;
         tmr_reload[t]    = '0;
         tmr_loops[t]     = '0;
      end
      bank_ms = '0;
   endfunction

   // applies one command to the shadow bank, returns 1 when a tick result is due
   function automatic bit apply_timer_command(input logic [2:0] cmd, input logic [2:0] idx,
                                              input logic [31:0] period,
                                              input logic [7:0] loops,
                                              output tick_result_type res);
      int t;
      res = '0;
      if (cmd == CMD_TICK) begin
         bank_ms = bank_ms + TICK_STEP;
         for (t = 0; t < NUM_TIMERS; t++) begin
            if (!tmr_active[t] || tmr_paused[t]) continue;
            if (tmr_remaining[t] > TICK_STEP) begin
               tmr_remaining[t] = tmr_remaining[t] - TICK_STEP;
               continue;
            end
            if (tmr_loops[t] == LOOP_FOREVER) begin
               tmr_remaining[t] = tmr_reload[t];
            end else if (tmr_loops[t] > 8'd1) begin
               tmr_loops[t]     = tmr_loops[t] - 8'd1;
               tmr_remaining[t] = tmr_reload[t];
            end else begin
               tmr_loops[t]     = '0;
               tmr_remaining[t] = '0;
               tmr_active[t]    = 1'b0;
            end
            if (t < MASK_W) res.mask[t] = 1'b1;
         end
         res.now_ms = bank_ms;
         return 1'b1;
      end
      if (int'(idx) < NUM_TIMERS) begin
         case (cmd)
            CMD_START: begin
               tmr_reload[idx]    = period;
               tmr_remaining[idx] = period;
               tmr_loops[idx]     = loops;
               tmr_active[idx]    = 1'b1;
               tmr_paused[idx]    = 1'b0;
            end
            CMD_STOP: begin
               tmr_active[idx]    = 1'b0;
               tmr_paused[idx]    = 1'b0;
               tmr_remaining[idx] = '0;
            end
            CMD_PAUSE: begin
               if (tmr_active[idx]) tmr_paused[idx] = 1'b1;
            end
            CMD_RESUME: begin
               if (tmr_active[idx]) tmr_paused[idx] = 1'b0;
            end
            default: ;
         endcase
      end
      return 1'b0;
   endfunction

   // accepted items feed the shadow bank, accepted results are checked in order
   always @(posedge clock) begin
      tick_result_type due;
      tick_result_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            items_accepted++;
            if (apply_timer_command(req_command, req_timer_index, req_period_ms,
                                    req_loop_count, due))
               pending_ticks.push_back(due);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_ticks.size() == 0) begin
               $error("tick result with none pending: mask %h time %0d",
                      rsp_expired_mask, rsp_time_ms);
               errors++;
            end else begin
               want = pending_ticks.pop_front();
               ticks_checked++;
               expirations_seen += $countones(rsp_expired_mask);
               if (rsp_expired_mask !== want.mask) begin
                  $error("expired_mask: expected %h, actual %h", want.mask, rsp_expired_mask);
                  errors++;
               end
               if (rsp_time_ms !== want.now_ms) begin
                  $error("time_ms: expected %0d, actual %0d", want.now_ms, rsp_time_ms);
                  errors++;
               end
            end
         end
      end
   end

   // receiver stalls come in bursts so a finished walk can meet a held result
   always @(negedge clock) begin
      if (no_idle) begin
         rsp_burst_left <= 0;
         rsp_stall      <= 1'b0;
      end else if (rsp_burst_left > 0) begin
         rsp_burst_left <= rsp_burst_left - 1;
         rsp_stall      <= 1'b1;
      end else if ($urandom_range(99) < 2) begin
         rsp_burst_left <= $urandom_range(0, 13);
         rsp_stall      <= 1'b1;
      end else begin
         rsp_stall      <= 1'b0;
      end
   end

   // called at a falling edge, returns at the falling edge after the item is taken
   task automatic send_item(input logic [2:0] cmd, input logic [2:0] idx,
                            input logic [31:0] period, input logic [7:0] loops);
      int target;
      if (!no_idle && $urandom_range(99) < 14) begin
         req_valid       <= 1'b0;
         req_command     <= 3'($urandom);
         req_timer_index <= 3'($urandom);
         req_period_ms   <= $urandom;
         req_loop_count  <= 8'($urandom);
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_timer_index <= idx;
      req_period_ms   <= period;
      req_loop_count  <= loops;
      target = items_accepted + 1;
      do @(negedge clock); while (items_accepted != target);
   endtask

   task automatic test_one_shot_and_zero_period();
      send_item(CMD_TICK, 3'd0, 32'd0, 8'd0);
      send_item(CMD_START, 3'd0, 32'd0, 8'd0);
      send_item(CMD_TICK, 3'd0, 32'd0, 8'd0);
      send_item(CMD_START, 3'd3, 32'd0, 8'd1);
      send_item(CMD_TICK, 3'd0, 32'd0, 8'd0);
      send_item(CMD_TICK, 3'd0, 32'd0, 8'd0);
   endtask

   task automatic test_repeat_counts();
      send_item(CMD_START, 3'd1, 32'd2, LOOP_FOREVER);
      send_item(CMD_START, 3'd2, 32'd1, 8'd3);
      send_item(CMD_START, 3'd5, 32'd0, 8'd2);
      repeat (4) send_item(CMD_TICK, 3'd0, 32'd0, 8'd0);
   endtask

   task automatic test_pause_resume_stop();
      // pause and resume of an idle timer do nothing
      send_item(CMD_PAUSE, 3'd4, 32'd0, 8'd0);
      send_item(CMD_RESUME, 3'd4, 32'd0, 8'd0);
      send_item(CMD_START, 3'd7, 32'hFFFF_FFFF, LOOP_FOREVER);
      send_item(CMD_START, 3'd6, 32'd1, 8'd0);
      send_item(CMD_PAUSE, 3'd6, 32'd0, 8'd0);
      send_item(CMD_TICK, 3'd0, 32'd0, 8'd0);
      send_item(CMD_RESUME, 3'd6, 32'd0, 8'd0);
      send_item(CMD_STOP, 3'd1, 32'd0, 8'd0);
      // a start of a timer that has already run out loads it anew
      send_item(CMD_START, 3'd2, 32'd1, LOOP_FOREVER);
      send_item(CMD_TICK, 3'd0, 32'd0, 8'd0);
   endtask

   task automatic test_undefined_commands();
      // codes past resume carry no meaning
      send_item(CMD_RESUME + 3'd1, 3'd2, 32'hFFFF_FFFF, 8'hFF);
      send_item(CMD_RESUME + 3'd2, 3'd7, 32'd0, 8'd0);
      send_item(CMD_RESUME + 3'd3, 3'd0, 32'hA5A5_5A5A, 8'h5A);
      send_item(CMD_TICK, 3'd0, 32'd0, 8'd0);
   endtask

   // mostly ticks with short periods so timers keep expiring and reloading
   task automatic test_random_traffic(input int count, input bit back_to_back);
      int pick;
      logic [2:0]  cmd;
      logic [31:0] period;
      logic [7:0]  loops;
      no_idle = back_to_back;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 55)      cmd = CMD_TICK;
         else if (pick < 75) cmd = CMD_START;
         else if (pick < 83) cmd = CMD_STOP;
         else if (pick < 90) cmd = CMD_PAUSE;
         else if (pick < 97) cmd = CMD_RESUME;
         else                cmd = CMD_RESUME + 3'($urandom_range(1, 3));
         pick = $urandom_range(99);
         if (pick < 85)      period = $urandom_range(0, 8);
         else if (pick < 95) period = $urandom;
         else                period = (pick & 1) ? 32'hFFFF_FFFF : 32'd1;
         pick = $urandom_range(99);
         if (pick < 30)      loops = LOOP_FOREVER;
         else if (pick < 50) loops = 8'($urandom_range(0, 1));
         else if (pick < 85) loops = 8'($urandom_range(2, 6));
         else                loops = 8'($urandom);
         send_item(cmd, 3'($urandom_range(0, 7)), period, loops);
      end
      no_idle = 1'b0;
   endtask

   initial begin
      clear_bank();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_one_shot_and_zero_period();
      test_repeat_counts();
      test_pause_resume_stop();
      test_undefined_commands();
      test_random_traffic(300, 1'b0);
      test_random_traffic(200, 1'b1);
      test_random_traffic(250, 1'b0);

      req_valid <= 1'b0;
      while (pending_ticks.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("run covered %0d command items and %0d tick results", items_accepted,
               ticks_checked);
      $display("timer expirations reported: %0d, mismatches: %0d", expirations_seen, errors);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- files.f -----
sv/ptb_pkg.sv
sv/ptb_step.sv
sv/periodic_timer_bank_top.sv
tb/sv/periodic_timer_bank_top_tb.sv
